// ----- sv/fcal_pkg.sv -----
// Shared types and constants for the FLAC cover-art locator.
// Used by the parser, the result buffer, the top level and the checker.
package fcal_pkg;

   localparam int DEFAULT_POSITION_BITS = 32;

   localparam logic [31:0] FLAC_MAGIC   = 32'h664C_6143;
   localparam logic [6:0]  TYPE_PICTURE = 7'd6;
   localparam logic [31:0] PIC_FRONT    = 32'd3;
   localparam logic [31:0] DIMS_BYTES   = 32'd16;
   localparam logic [2:0]  FIELD_BYTES  = 3'd4;
   localparam int          RSP_DATA_BITS = 72;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_HEADER,
      PH_SKIPBLOCK,
      PH_PTYPE,
      PH_MIMELEN,
      PH_MIMESKIP,
      PH_DESCLEN,
      PH_DESCSKIP,
      PH_DIMS,
      PH_DATALEN,
      PH_TAIL,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      OUT_FRONT    = 3'd0,
      OUT_FALLBACK = 3'd1,
      OUT_NONE     = 3'd2,
      OUT_NOT_FLAC = 3'd3,
      OUT_SHORT    = 3'd4
   } outcome_type;

   typedef struct packed {
      logic [31:0] cover_size;
      logic [31:0] cover_offset;
      outcome_type outcome;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } rsp_push_type;

endpackage

// ----- sv/flac_cover_art_locator.sv -----
// Top level of the FLAC cover-art locator.
// Depends on fcal_pkg, fcal_parser and fcal_rsp_fifo.
//
// Usage: the file streams in one byte per req transfer. req_tuser marks the
// first byte of a file and restarts the parse; req_tlast marks the last byte.
// At most one result per file leaves on the rsp channel: an outcome code with
// the offset and length of the picture data (zero when there is no picture).
// A front cover is reported on the transfer that completes its data length;
// otherwise the result follows a bad magic word, the end of the metadata, the
// end of the file, or a picture block that overruns its length. Bytes after a
// result are dropped until the next start mark.
// Throughput is one byte per cycle. A result pushed into an empty buffer is on
// rsp the cycle after its byte. Results wait in a two-entry buffer, so the
// block keeps taking bytes while one result is stalled; req_tready falls only
// when both entries are occupied and stays low until the receiver takes one.
// Synchronous reset puts the parser in front of a new file (as if a start mark
// had been seen) and empties the buffer; req_tready is high right after it.
module flac_cover_art_locator
   import fcal_pkg::*;
#(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // [7:0] data_byte
   input  logic                     req_tuser,  // [0] start_of_file
   input  logic                     req_tlast,  // end_of_file
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata   // [2:0] outcome, [34:3] cover_offset,
                                                // [66:35] cover_size, [71:67] zero
);

   rsp_push_type push;
   rsp_type      rsp;
   logic         space;
   logic         accept;

   assign req_tready = space;
   assign accept     = req_tvalid && space;

   fcal_parser #(
      .POSITION_BITS(POSITION_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .start_of_file (req_tuser),
      .end_of_file   (req_tlast),
      .push          (push)
   );

   fcal_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.cover_size, rsp.cover_offset, rsp.outcome};

endmodule

// ----- sv/fcal_parser.sv -----
// Byte-wise FLAC metadata walker: magic check, block headers, PICTURE fields.
// Depends on fcal_pkg; produces at most one result per file into the buffer.
module fcal_parser
   import fcal_pkg::*;
#(
   parameter int POSITION_BITS = DEFAULT_POSITION_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   data_byte,
   input  logic         start_of_file,
   input  logic         end_of_file,
   output rsp_push_type push
);

   phase_type                phase_ff,    phase_in;
   logic [2:0]               cnt_ff,      cnt_in;
   logic [31:0]              shift_ff,    shift_in;
   logic [31:0]              skip_ff,     skip_in;
   logic [23:0]              len_ff,      len_in;
   logic [31:0]              consumed_ff, consumed_in;
   logic                     last_ff,     last_in;
   logic                     front_ff,    front_in;
   logic [POSITION_BITS-1:0] pos_ff,      pos_in;
   logic                     fbv_ff,      fbv_in;
   logic [31:0]              fbo_ff,      fbo_in;
   logic [31:0]              fbs_ff,      fbs_in;
   logic                     sent_ff,     sent_in;

   always_comb begin : step
      logic [31:0] take_shift;
      logic [2:0]  take_cnt;
      logic        take_done;
      logic [31:0] skip_dec;
      logic        skip_zero;
      logic [31:0] len_ext;
      logic        do_finish;
      logic        do_emit;
      outcome_type emit_code;
      logic [31:0] emit_off;
      logic [31:0] emit_size;
      logic [31:0] cur_off;

      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      shift_in    = shift_ff;
      skip_in     = skip_ff;
      len_in      = len_ff;
      consumed_in = consumed_ff;
      last_in     = last_ff;
      front_in    = front_ff;
      pos_in      = pos_ff;
      fbv_in      = fbv_ff;
      fbo_in      = fbo_ff;
      fbs_in      = fbs_ff;
      sent_in     = sent_ff;
      take_shift  = '0;
      take_cnt    = '0;
      take_done   = 1'b0;
      skip_dec    = '0;
      skip_zero   = 1'b0;
      len_ext     = '0;
      do_finish   = 1'b0;
      do_emit     = 1'b0;
      emit_code   = OUT_NONE;
      emit_off    = '0;
      emit_size   = '0;
      cur_off     = '0;

      if (accept) begin
         if (start_of_file) begin
            phase_in    = PH_MAGIC;
            cnt_in      = '0;
            shift_in    = '0;
            skip_in     = '0;
            len_in      = '0;
            consumed_in = '0;
            last_in     = 1'b0;
            front_in    = 1'b0;
            pos_in      = '0;
            fbv_in      = 1'b0;
            fbo_in      = '0;
            fbs_in      = '0;
            sent_in     = 1'b0;
         end

         if (phase_in != PH_DONE) begin
            pos_in = pos_in + 1'b1;
            if (phase_in >= PH_PTYPE && phase_in <= PH_DATALEN && consumed_in != '1) begin
               consumed_in = consumed_in + 32'd1;
            end

            // Shared field shifter: four bytes make one big-endian word.
            take_shift = {shift_in[23:0], data_byte};
            take_cnt   = cnt_in + 3'd1;
            take_done  = (take_cnt >= FIELD_BYTES);
            skip_dec   = (skip_in != '0) ? skip_in - 32'd1 : skip_in;
            skip_zero  = (skip_dec == '0);
            len_ext    = {8'd0, len_in};
            cur_off    = 32'(pos_in);

            unique case (phase_in) inside
               PH_MAGIC, PH_HEADER, PH_PTYPE, PH_MIMELEN, PH_DESCLEN, PH_DATALEN: begin
                  shift_in = take_shift;
                  cnt_in   = take_done ? 3'd0 : take_cnt;
               end
               default: begin
               end
            endcase

            unique case (phase_in) inside
               PH_MAGIC: begin
                  if (take_done) begin
                     if (take_shift == FLAC_MAGIC) begin
                        phase_in = PH_HEADER;
                     end else begin
                        do_emit   = 1'b1;
                        emit_code = OUT_NOT_FLAC;
                     end
                  end
               end
               PH_HEADER: begin
                  if (take_done) begin
                     last_in = take_shift[31];
                     len_in  = take_shift[23:0];
                     if (take_shift[30:24] != TYPE_PICTURE) begin
                        if (take_shift[23:0] != '0) begin
                           skip_in  = {8'd0, take_shift[23:0]};
                           phase_in = PH_SKIPBLOCK;
                        end else if (take_shift[31]) begin
                           do_finish = 1'b1;
                        end else begin
                           phase_in = PH_HEADER;
                        end
                     end else begin
                        consumed_in = '0;
                        phase_in    = PH_PTYPE;
                     end
                  end
               end
               PH_SKIPBLOCK, PH_TAIL: begin
                  skip_in = skip_dec;
                  if (skip_zero) begin
                     if (last_in) begin
                        do_finish = 1'b1;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
               PH_PTYPE: begin
                  if (take_done) begin
                     front_in = (take_shift == PIC_FRONT);
                     phase_in = PH_MIMELEN;
                  end
               end
               PH_MIMELEN: begin
                  if (take_done) begin
                     skip_in  = take_shift;
                     phase_in = (take_shift != '0) ? PH_MIMESKIP : PH_DESCLEN;
                  end
               end
               PH_MIMESKIP: begin
                  skip_in = skip_dec;
                  if (skip_zero) begin
                     phase_in = PH_DESCLEN;
                  end
               end
               PH_DESCLEN: begin
                  if (take_done) begin
                     if (take_shift != '0) begin
                        skip_in  = take_shift;
                        phase_in = PH_DESCSKIP;
                     end else begin
                        skip_in  = DIMS_BYTES;
                        phase_in = PH_DIMS;
                     end
                  end
               end
               PH_DESCSKIP: begin
                  skip_in = skip_dec;
                  if (skip_zero) begin
                     skip_in  = DIMS_BYTES;
                     phase_in = PH_DIMS;
                  end
               end
               PH_DIMS: begin
                  skip_in = skip_dec;
                  if (skip_zero) begin
                     phase_in = PH_DATALEN;
                  end
               end
               PH_DATALEN: begin
                  if (take_done) begin
                     if (take_shift != '0 && front_in) begin
                        do_emit   = 1'b1;
                        emit_code = OUT_FRONT;
                        emit_off  = cur_off;
                        emit_size = take_shift;
                     end else begin
                        if (take_shift != '0 && !fbv_in) begin
                           fbv_in = 1'b1;
                           fbo_in = cur_off;
                           fbs_in = take_shift;
                        end
                        // A picture whose fields run past the block length ends the search.
                        if (consumed_in > len_ext) begin
                           do_finish = 1'b1;
                        end else if (consumed_in != len_ext) begin
                           skip_in  = len_ext - consumed_in;
                           phase_in = PH_TAIL;
                        end else if (last_in) begin
                           do_finish = 1'b1;
                        end else begin
                           phase_in = PH_HEADER;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         if (!do_emit && !do_finish && end_of_file && !sent_in) begin
            if (phase_in == PH_MAGIC) begin
               do_emit   = 1'b1;
               emit_code = OUT_SHORT;
            end else begin
               do_finish = 1'b1;
            end
         end

         if (do_finish) begin
            do_emit = 1'b1;
            if (fbv_in) begin
               emit_code = OUT_FALLBACK;
               emit_off  = fbo_in;
               emit_size = fbs_in;
            end else begin
               emit_code = OUT_NONE;
            end
         end

         if (do_emit) begin
            sent_in  = 1'b1;
            phase_in = PH_DONE;
         end
      end

      push.valid            = do_emit;
      push.rsp.outcome      = emit_code;
      push.rsp.cover_offset = emit_off;
      push.rsp.cover_size   = emit_size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_MAGIC;
         cnt_ff      <= '0;
         shift_ff    <= '0;
         skip_ff     <= '0;
         len_ff      <= '0;
         consumed_ff <= '0;
         last_ff     <= 1'b0;
         front_ff    <= 1'b0;
         pos_ff      <= '0;
         fbv_ff      <= 1'b0;
         fbo_ff      <= '0;
         fbs_ff      <= '0;
         sent_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         shift_ff    <= shift_in;
         skip_ff     <= skip_in;
         len_ff      <= len_in;
         consumed_ff <= consumed_in;
         last_ff     <= last_in;
         front_ff    <= front_in;
         pos_ff      <= pos_in;
         fbv_ff      <= fbv_in;
         fbo_ff      <= fbo_in;
         fbs_ff      <= fbs_in;
         sent_ff     <= sent_in;
      end
   end

endmodule

// ----- sv/fcal_rsp_fifo.sv -----
// Two-entry result buffer between the parser and the result channel.
// Depends on fcal_pkg for the result record.
module fcal_rsp_fifo
   import fcal_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rsp_push_type push,
   output logic         space,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_type      rsp
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign space      = (count_ff != 2'd2);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push.valid;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push.valid} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/fcal_checker.sv -----
// Port-level checks for the FLAC cover-art locator, bound to the top level.
// Depends on fcal_pkg for outcome codes.
module fcal_checker
   import fcal_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [2:0] code;
   assign code = rsp_tdata[2:0];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or vanished while stalled");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> code <= OUT_SHORT && rsp_tdata[71:67] == '0)
      else $error("result carries an undefined outcome");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code == OUT_NONE || code == OUT_NOT_FLAC || code == OUT_SHORT)
      |-> rsp_tdata[66:3] == '0)
      else $error("offset or size set without a picture");

   a_picture_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (code == OUT_FRONT || code == OUT_FALLBACK) |-> rsp_tdata[66:35] != '0)
      else $error("picture reported with zero data length");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && $past(rsp_tvalid))
      else $error("input stalled with no result waiting");

endmodule

bind flac_cover_art_locator fcal_checker u_fcal_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the FLAC cover-art locator (flac_cover_art_locator).
// Streams directed and random FLAC files in, predicts each result in place and
// checks it field by field. Depends on fcal_pkg and the RTL only.
module tb_top
   import fcal_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = 8'h00;  // [7:0] data_byte
   logic                     req_tuser = 1'b0;   // [0] start_of_file
   logic                     req_tlast = 1'b0;   // end_of_file
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;          // [2:0] outcome, [34:3] cover_offset,
                                                 // [66:35] cover_size, [71:67] zero

   flac_cover_art_locator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Traffic shaping for the sender and the receiver, and run counters.
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          rsp_hold_left = 0;
   int unsigned bytes_sent = 0;
   int unsigned fail_count = 0;

   rsp_type     expected_covers[$];
   logic [7:0]  file_bytes[$];

   // Locator state as tracked by the predictor.
   phase_type   lc_phase;
   logic [2:0]  lc_count;
   logic [31:0] lc_word;
   logic [31:0] lc_skip;
   logic [23:0] lc_blk_len;
   logic [31:0] lc_blk_used;
   logic        lc_blk_last;
   logic        lc_front;
   logic [31:0] lc_pos;
   logic        lc_fb_valid;
   logic [31:0] lc_fb_offset;
   logic [31:0] lc_fb_size;
   logic        lc_reported;
   logic        lc_emitted;

   function automatic void clear_locator();
      lc_phase     = PH_MAGIC;
      lc_count     = '0;
      lc_word      = '0;
      lc_skip      = '0;
      lc_blk_len   = '0;
      lc_blk_used  = '0;
      lc_blk_last  = 1'b0;
      lc_front     = 1'b0;
      lc_pos       = '0;
      lc_fb_valid  = 1'b0;
      lc_fb_offset = '0;
      lc_fb_size   = '0;
      lc_reported  = 1'b0;
   endfunction

   function automatic void report_cover(outcome_type oc, logic [31:0] off, logic [31:0] size);
      rsp_type r;
      r.outcome      = oc;
      r.cover_offset = off;
      r.cover_size   = size;
      expected_covers.push_back(r);
      lc_reported = 1'b1;
      lc_emitted  = 1'b1;
      lc_phase    = PH_DONE;
   endfunction

   function automatic void report_metadata_end();
      if (lc_fb_valid)
         report_cover(OUT_FALLBACK, lc_fb_offset, lc_fb_size);
      else
         report_cover(OUT_NONE, '0, '0);
   endfunction

   function automatic void close_block();
      if (lc_blk_last)
         report_metadata_end();
      else
         lc_phase = PH_HEADER;
   endfunction

   // Big-endian word assembly; true once the fourth byte is in.
   function automatic bit shift_word(logic [7:0] b);
      lc_word  = {lc_word[23:0], b};
      lc_count = lc_count + 3'd1;
      if (lc_count >= FIELD_BYTES) begin
         lc_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void parse_byte(logic [7:0] b);
      lc_pos = lc_pos + 32'd1;
      if (lc_phase >= PH_PTYPE && lc_phase <= PH_DATALEN && lc_blk_used != '1)
         lc_blk_used = lc_blk_used + 32'd1;

      case (lc_phase) inside
         PH_MAGIC: begin
            if (shift_word(b)) begin
               if (lc_word == FLAC_MAGIC)
                  lc_phase = PH_HEADER;
               else
                  report_cover(OUT_NOT_FLAC, '0, '0);
            end
         end
         PH_HEADER: begin
            if (shift_word(b)) begin
               lc_blk_last = lc_word[31];
               lc_blk_len  = lc_word[23:0];
               if (lc_word[30:24] != TYPE_PICTURE) begin
                  if (lc_blk_len != 0) begin
                     lc_skip  = {8'h00, lc_blk_len};
                     lc_phase = PH_SKIPBLOCK;
                  end else begin
                     close_block();
                  end
               end else begin
                  lc_blk_used = '0;
                  lc_phase    = PH_PTYPE;
               end
            end
         end
         PH_SKIPBLOCK, PH_TAIL: begin
            if (lc_skip != 0)
               lc_skip = lc_skip - 32'd1;
            if (lc_skip == 0)
               close_block();
         end
         PH_PTYPE: begin
            if (shift_word(b)) begin
               lc_front = (lc_word == PIC_FRONT);
               lc_phase = PH_MIMELEN;
            end
         end
         PH_MIMELEN: begin
            if (shift_word(b)) begin
               lc_skip  = lc_word;
               lc_phase = (lc_word != 0) ? PH_MIMESKIP : PH_DESCLEN;
            end
         end
         PH_MIMESKIP: begin
            if (lc_skip != 0)
               lc_skip = lc_skip - 32'd1;
            if (lc_skip == 0)
               lc_phase = PH_DESCLEN;
         end
         PH_DESCLEN: begin
            if (shift_word(b)) begin
               if (lc_word != 0) begin
                  lc_skip  = lc_word;
                  lc_phase = PH_DESCSKIP;
               end else begin
                  lc_skip  = DIMS_BYTES;
                  lc_phase = PH_DIMS;
               end
            end
         end
         PH_DESCSKIP: begin
            if (lc_skip != 0)
               lc_skip = lc_skip - 32'd1;
            if (lc_skip == 0) begin
               lc_skip  = DIMS_BYTES;
               lc_phase = PH_DIMS;
            end
         end
         PH_DIMS: begin
            if (lc_skip != 0)
               lc_skip = lc_skip - 32'd1;
            if (lc_skip == 0)
               lc_phase = PH_DATALEN;
         end
         PH_DATALEN: begin
            if (shift_word(b)) begin
               // The data offset is the position just past the length word.
               if (lc_word != 0 && lc_front) begin
                  report_cover(OUT_FRONT, lc_pos, lc_word);
                  return;
               end
               if (lc_word != 0 && !lc_fb_valid) begin
                  lc_fb_valid  = 1'b1;
                  lc_fb_offset = lc_pos;
                  lc_fb_size   = lc_word;
               end
               if (lc_blk_used > {8'h00, lc_blk_len}) begin
                  report_metadata_end();
               end else if ({8'h00, lc_blk_len} != lc_blk_used) begin
                  lc_skip  = {8'h00, lc_blk_len} - lc_blk_used;
                  lc_phase = PH_TAIL;
               end else begin
                  close_block();
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_cover(logic [7:0] b, logic sof, logic eof);
      lc_emitted = 1'b0;
      if (sof)
         clear_locator();
      if (lc_phase != PH_DONE)
         parse_byte(b);
      if (!lc_emitted && eof && !lc_reported) begin
         if (lc_phase == PH_MAGIC)
            report_cover(OUT_SHORT, '0, '0);
         else
            report_metadata_end();
      end
   endfunction

   // ---------------------------------------------------------------- file building

   function automatic void put_word(logic [31:0] v);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_random(int n);
      for (int i = 0; i < n; i++)
         file_bytes.push_back(8'($urandom()));
   endfunction

   function automatic void put_header(logic last, logic [6:0] kind, logic [23:0] len);
      put_word({last, kind, len});
   endfunction

   // A picture block; len_cut shortens the declared length below its contents.
   function automatic void put_picture(logic last, logic [31:0] ptype, int mime_n,
                                       int desc_n, logic [31:0] pic_bytes, int tail_n,
                                       int len_cut);
      put_header(last, TYPE_PICTURE, 24'(32 + mime_n + desc_n + tail_n - len_cut));
      put_word(ptype);
      put_word(mime_n);
      put_random(mime_n);
      put_word(desc_n);
      put_random(desc_n);
      put_random(16);
      put_word(pic_bytes);
      put_random(tail_n);
   endfunction

   // ---------------------------------------------------------------- traffic

   task automatic send_byte(logic [7:0] b, logic sof, logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_cover(b, sof, eof);
      bytes_sent++;
   endtask

   task automatic send_file(logic sof_first, int count, logic eof_last);
      for (int i = 0; i < count; i++)
         send_byte(file_bytes[i], sof_first && i == 0, eof_last && i == count - 1);
      file_bytes.delete();
   endtask

   // The sender stops offering bytes while the results drain.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_covers.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_cover
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_covers.size() == 0) begin
            $error("result transfer with no result expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_covers.pop_front();
            if (rsp_tdata[2:0] !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_tdata[2:0]);
               fail_count++;
            end
            if (rsp_tdata[34:3] !== want.cover_offset) begin
               $error("cover_offset: expected %0h, got %0h",
                      want.cover_offset, rsp_tdata[34:3]);
               fail_count++;
            end
            if (rsp_tdata[66:35] !== want.cover_size) begin
               $error("cover_size: expected %0h, got %0h",
                      want.cover_size, rsp_tdata[66:35]);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // Right after reset the parser already expects a file, without a start mark.
   task automatic test_no_start_mark();
      put_word(FLAC_MAGIC);
      put_header(1'b0, 7'd0, 24'd3);
      put_random(3);
      put_picture(1'b1, PIC_FRONT, 2, 1, 32'hFFFF_FFFF, 2, 0);
      put_random(3);
      send_file(1'b0, file_bytes.size(), 1'b1);
   endtask

   // One to three bytes are too short; the bare magic holds no picture.
   task automatic test_short_files();
      for (int n = 1; n <= 4; n++) begin
         put_word(FLAC_MAGIC);
         send_file(1'b1, n, 1'b1);
      end
   endtask

   task automatic test_bad_magic();
      put_word(32'h664C_6144);
      put_random(5);
      send_file(1'b1, 9, 1'b1);
      // Nothing more may come out until the next start mark.
      put_random(3);
      send_file(1'b0, 3, 1'b1);
   endtask

   task automatic test_front_cover();
      put_word(FLAC_MAGIC);
      put_header(1'b0, 7'd4, 24'd0);
      put_picture(1'b0, 32'd0, 0, 0, 32'd0, 1, 0);
      put_picture(1'b1, PIC_FRONT, 0, 0, 32'h0000_0001, 0, 0);
      put_random(4);
      send_file(1'b1, file_bytes.size(), 1'b1);
   endtask

   task automatic test_fallback();
      put_word(FLAC_MAGIC);
      put_picture(1'b0, 32'd1, 3, 0, 32'h00AB_CDEF, 2, 0);
      put_picture(1'b0, 32'd4, 0, 2, 32'h1234_5678, 0, 0);
      put_picture(1'b0, PIC_FRONT, 1, 1, 32'd0, 0, 0);
      put_header(1'b1, 7'h7F, 24'd1);
      put_random(3);
      send_file(1'b1, file_bytes.size(), 1'b1);
   endtask

   task automatic test_no_picture();
      put_word(FLAC_MAGIC);
      put_header(1'b0, 7'd0, 24'd2);
      put_word(32'h00FF_00FF);
      put_header(1'b0, 7'd3, 24'd0);
      put_header(1'b1, 7'h7F, 24'd0);
      put_random(2);
      send_file(1'b1, file_bytes.size(), 1'b1);
   endtask

   task automatic test_overrun();
      put_word(FLAC_MAGIC);
      put_picture(1'b0, 32'd2, 1, 1, 32'd9, 2, 5);
      send_file(1'b1, file_bytes.size(), 1'b0);
      put_word(FLAC_MAGIC);
      put_picture(1'b0, PIC_FRONT, 0, 0, 32'd77, 0, 20);
      send_file(1'b1, file_bytes.size(), 1'b0);
      put_word(FLAC_MAGIC);
      put_picture(1'b0, 32'd2, 0, 0, 32'd0, 0, 1);
      send_file(1'b1, file_bytes.size(), 1'b1);
   endtask

   task automatic test_truncated();
      put_word(FLAC_MAGIC);
      put_picture(1'b0, 32'd5, 0, 0, 32'd3, 4, 0);
      put_header(1'b0, 7'd1, 24'd10);
      put_random(10);
      send_file(1'b1, file_bytes.size() - 4, 1'b1);
      put_word(FLAC_MAGIC);
      put_picture(1'b1, PIC_FRONT, 0, 0, 32'd5, 0, 0);
      send_file(1'b1, 12, 1'b1);
   endtask

   // The receiver holds off while short bad files keep producing results.
   task automatic test_backpressure();
      rsp_hold_left = 200;
      for (int i = 0; i < 12; i++) begin
         put_word(FLAC_MAGIC ^ (32'd1 << $urandom_range(31)));
         send_file(1'b1, 4, 1'b0);
      end
      wait_drained();
   endtask

   task automatic send_random_file();
      int          nblk;
      int          mime_n;
      int          desc_n;
      int          tail_n;
      int          cut;
      int          count;
      logic [6:0]  kind;
      logic [31:0] ptype;
      logic [31:0] pic_bytes;
      logic        last;
      if ($urandom_range(9) == 0) begin
         put_random($urandom_range(1, 12));
         send_file(1'b1, file_bytes.size(), 1'b1);
         return;
      end
      if ($urandom_range(19) == 0)
         put_word($urandom());
      else
         put_word(FLAC_MAGIC);
      nblk = $urandom_range(1, 4);
      for (int i = 0; i < nblk; i++) begin
         last = (i == nblk - 1) && ($urandom_range(9) != 0);
         if ($urandom_range(1) == 1) begin
            case ($urandom_range(3))
               0:       ptype = PIC_FRONT;
               1:       ptype = $urandom();
               default: ptype = $urandom_range(20);
            endcase
            case ($urandom_range(3))
               0:       pic_bytes = '0;
               1:       pic_bytes = $urandom_range(1, 1000);
               default: pic_bytes = $urandom();
            endcase
            mime_n = $urandom_range(5);
            desc_n = $urandom_range(5);
            tail_n = $urandom_range(4);
            cut    = ($urandom_range(7) == 0) ? $urandom_range(1, 20) : 0;
            if (cut > 32 + mime_n + desc_n + tail_n)
               cut = 32 + mime_n + desc_n + tail_n;
            put_picture(last, ptype, mime_n, desc_n, pic_bytes, tail_n, cut);
         end else begin
            kind = 7'($urandom_range(127));
            if (kind == TYPE_PICTURE)
               kind = 7'h7F;
            count = $urandom_range(8);
            put_header(last, kind, 24'(count));
            put_random(count);
         end
      end
      put_random($urandom_range(6));
      count = file_bytes.size();
      if ($urandom_range(6) == 0)
         count = $urandom_range(1, count);
      send_file($urandom_range(19) != 0, count, $urandom_range(9) != 0);
   endtask

   task automatic test_random_files();
      int unsigned first_byte;
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 59;
            end
            1: begin
               send_idle_pct = 59;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         first_byte = bytes_sent;
         while (bytes_sent - first_byte < 100) begin
            send_random_file();
            if ($urandom_range(9) == 0)
               wait_drained();
         end
      end
   endtask

   initial begin
      clear_locator();
      send_idle_pct = 9;
      recv_idle_pct = 59;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_no_start_mark();
      test_short_files();
      test_bad_magic();
      test_front_cover();
      test_fallback();
      test_no_picture();
      test_overrun();
      test_truncated();
      test_backpressure();
      test_random_files();
      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- flac_cover_art_locator.f -----
sv/fcal_pkg.sv
sv/fcal_parser.sv
sv/fcal_rsp_fifo.sv
sv/flac_cover_art_locator.sv
sv/fcal_checker.sv
bench/tb_top.sv
